FILE: hw/rtl/twc_pkg.sv
// shared types, constants and the wave lookup for the triangle channel
package twc_pkg;

  localparam int PeriodWidth = 16;
  localparam int CountWidth  = 8;
  localparam int StepWidth   = 5;
  localparam int SampleWidth = 4;
  localparam int ModeWidth   = 4;
  localparam int DataWidth   = 8;

  localparam logic [PeriodWidth-1:0] LowMask  = 16'h00FF;
  localparam logic [PeriodWidth-1:0] HighMask = 16'hFF00;

  typedef enum logic [ModeWidth-1:0] {
    MODE_TIMER        = 4'd0,
    MODE_QUARTER      = 4'd1,
    MODE_HALF         = 4'd2,
    MODE_HALT         = 4'd3,
    MODE_LINEAR       = 4'd4,
    MODE_PERIOD_LOW   = 4'd5,
    MODE_PERIOD_HIGH  = 4'd6,
    MODE_LENGTH       = 4'd7,
    MODE_RESET        = 4'd8
  } mode_t;

  // 32-step sequence: 15 down to 0, then 0 up to 15
  function automatic logic [SampleWidth-1:0] wave_value(input logic [StepWidth-1:0] step);
    logic [SampleWidth-1:0] low;
    low = step[SampleWidth-1:0];
    if (step[StepWidth-1]) begin
      return low;
    end
    return ~low;
  endfunction

endpackage

FILE: hw/rtl/twc_state.sv
// channel state registers, event decode and sample selection
module twc_state (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           update,
  input  logic [twc_pkg::ModeWidth-1:0]  mode,
  input  logic [twc_pkg::DataWidth-1:0]  write_data,
  output logic [twc_pkg::SampleWidth-1:0] sample_next
);
  import twc_pkg::*;

  logic [PeriodWidth-1:0] period_reload, period_reload_next;
  logic [PeriodWidth-1:0] period_count, period_count_next;
  logic [StepWidth-1:0]   step_index, step_index_next;
  logic [CountWidth-1:0]  linear_reload, linear_reload_next;
  logic [CountWidth-1:0]  linear_count, linear_count_next;
  logic                   reload_pending, reload_pending_next;
  logic                   halt_flag, halt_flag_next;
  logic [CountWidth-1:0]  length_count, length_count_next;

  always_comb begin
    period_reload_next  = period_reload;
    period_count_next   = period_count;
    step_index_next     = step_index;
    linear_reload_next  = linear_reload;
    linear_count_next   = linear_count;
    reload_pending_next = reload_pending;
    halt_flag_next      = halt_flag;
    length_count_next   = length_count;
    case (mode_t'(mode))
      MODE_TIMER: begin
        if (period_count == '0) begin
          period_count_next = period_reload;
          step_index_next   = step_index + StepWidth'(1);
        end else begin
          period_count_next = period_count - PeriodWidth'(1);
        end
      end
      MODE_QUARTER: begin
        if (reload_pending) begin
          linear_count_next = linear_reload;
        end else if (linear_count != '0) begin
          linear_count_next = linear_count - CountWidth'(1);
        end
        if (!halt_flag) begin
          reload_pending_next = 1'b0;
        end
      end
      MODE_HALF: begin
        if (length_count != '0 && !halt_flag) begin
          length_count_next = length_count - CountWidth'(1);
        end
      end
      MODE_HALT: begin
        halt_flag_next = write_data[0];
      end
      MODE_LINEAR: begin
        linear_reload_next = write_data;
      end
      MODE_PERIOD_LOW: begin
        period_reload_next = (period_reload & HighMask) | PeriodWidth'(write_data);
      end
      MODE_PERIOD_HIGH: begin
        period_reload_next  = (period_reload & LowMask) | {write_data, 8'h00};
        reload_pending_next = 1'b1;
      end
      MODE_LENGTH: begin
        length_count_next = write_data;
      end
      MODE_RESET: begin
        length_count_next = '0;
        halt_flag_next    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sample as it stands after the event
  always_comb begin
    if (linear_count_next != '0 && length_count_next != '0) begin
      sample_next = wave_value(step_index_next);
    end else begin
      sample_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_reload  <= '0;
      period_count   <= '0;
      step_index     <= '0;
      linear_reload  <= '0;
      linear_count   <= '0;
      reload_pending <= 1'b0;
      halt_flag      <= 1'b1;
      length_count   <= '0;
    end else if (update) begin
      period_reload  <= period_reload_next;
      period_count   <= period_count_next;
      step_index     <= step_index_next;
      linear_reload  <= linear_reload_next;
      linear_count   <= linear_count_next;
      reload_pending <= reload_pending_next;
      halt_flag      <= halt_flag_next;
      length_count   <= length_count_next;
    end
  end

endmodule

FILE: hw/rtl/triangle_wave_channel_core.sv
// top level of the triangle-wave sound channel
//
// Event-driven triangle channel. Each transfer on the input channel is one event
// (timer tick, quarter frame, half frame, register write or channel reset) and
// produces exactly one transfer on the output channel carrying the 4-bit sample
// as it stands after that event. Each event passes first through the input
// register, then through the state update into the output register. One
// event is accepted per cycle when the output side is not stalling; a stall on
// the output holds the output register, and once the input register is also
// occupied it raises in_stall in the same cycle.
// The sample is zero unless both the linear and the length counters are nonzero;
// the 32-step sequence keeps advancing on timer ticks regardless.
module triangle_wave_channel_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [twc_pkg::ModeWidth-1:0]   mode,
  input  logic [twc_pkg::DataWidth-1:0]   write_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [twc_pkg::SampleWidth-1:0] sample
);
  import twc_pkg::*;

  // input register
  logic                   s1_valid;
  logic [ModeWidth-1:0]   s1_mode;
  logic [DataWidth-1:0]   s1_data;

  logic                   advance;
  logic [SampleWidth-1:0] sample_next;

  // the output register frees up when empty or being taken this cycle
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_mode <= mode;
      s1_data <= write_data;
    end
  end

  // state applies the event exactly once, as it moves to the output register
  twc_state u_state (
    .clk         (clk),
    .rst         (rst),
    .update      (s1_valid && advance),
    .mode        (s1_mode),
    .write_data  (s1_data),
    .sample_next (sample_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      sample <= sample_next;
    end
  end

endmodule
